// ===== sv/mtg_pkg.sv =====
// Shared constants, state codes and word functions of the MT19937 generator.
package mtg_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned STATE_WORDS   = 624;
  localparam int unsigned MIDDLE_OFFSET = 397;

  localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;
  localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

  typedef enum logic [5:0] {
    S_SEED  = 6'b000001,
    S_MUL   = 6'b000010,
    S_ADD   = 6'b000100,
    S_LOAD  = 6'b001000,
    S_READY = 6'b010000,
    S_CALC  = 6'b100000
  } state_e;

  function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] cur,
                                              input logic [WORD_W-1:0] nxt,
                                              input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] t;
    y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    t = y >> 1;
    if (y[0]) begin
      t = t ^ TWIST_MATRIX;
    end
    return far ^ t;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y1;
    logic [WORD_W-1:0] y2;
    logic [WORD_W-1:0] y3;
    y1 = w ^ (w >> 11);
    y2 = y1 ^ ((y1 << 7) & TEMPER_B);
    y3 = y2 ^ ((y2 << 15) & TEMPER_C);
    return y3 ^ (y3 >> 18);
  endfunction

endpackage

// ===== sv/mtg_req_if.sv =====
// Request channel: one beat asks for one random word.
interface mtg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ===== sv/mtg_rsp_if.sv =====
// Response channel: one beat carries one tempered random word.
interface mtg_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [mtg_pkg::WORD_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/mersenne_twister_generator_unit.sv =====
// MT19937 generator top level: seed register, fill sequencer, per-word twist and tempering.
//
// One request beat yields one tempered 32-bit MT19937 word. A normal draw reads the next and
// the far state word from two mirrored RAMs when the request is taken, then twists the
// current word, writes it back and loads the output register; the next request is taken as
// soon as that register is free or being drained. The state is regenerated one word per
// draw instead of in a block. After reset, and for a request with restart set, the store
// is refilled from the seed register, each word through a registered 32x32 multiply
// (S_MUL) and a write (S_ADD); ready stays low during the refill, and a restart request
// returns its word once the refill is done. Write the seed only while idle.
module mersenne_twister_generator_unit #(
  parameter int unsigned StateWords   = mtg_pkg::STATE_WORDS,
  parameter int unsigned MiddleOffset = mtg_pkg::MIDDLE_OFFSET
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mtg_pkg::WORD_W-1:0] cfg_wdata_i,
  mtg_req_if.sink                    req_i,
  mtg_rsp_if.source                  rsp_o
);

  localparam int unsigned AddrW = $clog2(StateWords);
  localparam int unsigned W     = mtg_pkg::WORD_W;

  mtg_pkg::state_e state_q, state_d;

  logic [W-1:0]     seed_q;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [AddrW-1:0] k_q, k_d;
  logic             pending_q, pending_d;
  logic             ovalid_q, ovalid_d;
  logic [W-1:0]     p_q, p_d;
  logic [W-1:0]     prod_q, prod_d;
  logic [W-1:0]     cache_q, cache_d;
  logic [W-1:0]     out_q, out_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [W-1:0]     ram_wdata;
  logic [AddrW-1:0] nxt_addr;
  logic [AddrW-1:0] far_addr;
  logic [AddrW:0]   far_sum;
  logic [W-1:0]     nxt_data;
  logic [W-1:0]     far_data;
  logic [W-1:0]     fill_word;
  logic [W-1:0]     new_word;
  logic             req_fire;
  logic             rsp_fire;

  assign nxt_addr = (pos_q == AddrW'(StateWords - 1)) ? '0 : pos_q + 1'b1;
  assign far_sum  = {1'b0, pos_q} + (AddrW + 1)'(MiddleOffset);
  assign far_addr = (far_sum >= (AddrW + 1)'(StateWords))
                  ? AddrW'(far_sum - (AddrW + 1)'(StateWords))
                  : far_sum[AddrW-1:0];

  assign fill_word = prod_q + W'(k_q);
  assign new_word  = mtg_pkg::twist(cache_q, nxt_data, far_data);

  assign req_i.ready = (state_q == mtg_pkg::S_READY) && (!ovalid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_fire    = ovalid_q && rsp_o.ready;
  assign rsp_o.valid = ovalid_q;
  assign rsp_o.value = out_q;

  mtg_ram #(.Width(W), .Depth(StateWords)) u_ram_nxt (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (nxt_addr),
    .rdata_o (nxt_data)
  );

  mtg_ram #(.Width(W), .Depth(StateWords)) u_ram_far (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (far_addr),
    .rdata_o (far_data)
  );

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    k_d       = k_q;
    pending_d = pending_q;
    ovalid_d  = ovalid_q && !rsp_fire;
    p_d       = p_q;
    prod_d    = prod_q;
    cache_d   = cache_q;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = new_word;
    case (state_q)
      mtg_pkg::S_SEED: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = seed_q;
        p_d       = seed_q;
        cache_d   = seed_q;
        k_d       = AddrW'(1);
        pos_d     = '0;
        state_d   = mtg_pkg::S_MUL;
      end
      mtg_pkg::S_MUL: begin
        prod_d  = mtg_pkg::INIT_MULT * (p_q ^ (p_q >> 30));
        state_d = mtg_pkg::S_ADD;
      end
      mtg_pkg::S_ADD: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_wdata = fill_word;
        p_d       = fill_word;
        k_d       = k_q + 1'b1;
        if (k_q == AddrW'(StateWords - 1)) begin
          state_d   = pending_q ? mtg_pkg::S_LOAD : mtg_pkg::S_READY;
          pending_d = 1'b0;
        end else begin
          state_d = mtg_pkg::S_MUL;
        end
      end
      mtg_pkg::S_LOAD: begin
        state_d = mtg_pkg::S_CALC;
      end
      mtg_pkg::S_READY: begin
        if (req_fire) begin
          if (req_i.restart) begin
            pending_d = 1'b1;
            state_d   = mtg_pkg::S_SEED;
          end else begin
            state_d = mtg_pkg::S_CALC;
          end
        end
      end
      mtg_pkg::S_CALC: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = new_word;
        out_d     = mtg_pkg::temper(new_word);
        ovalid_d  = 1'b1;
        cache_d   = nxt_data;
        pos_d     = nxt_addr;
        state_d   = mtg_pkg::S_READY;
      end
      default: begin
        state_d = mtg_pkg::S_SEED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mtg_pkg::S_SEED;
      seed_q    <= mtg_pkg::SEED_RESET;
      pos_q     <= '0;
      k_q       <= '0;
      pending_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      k_q       <= k_d;
      pending_q <= pending_d;
      ovalid_q  <= ovalid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    prod_q  <= prod_d;
    cache_q <= cache_d;
    out_q   <= out_d;
  end

  a_calc_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mtg_pkg::S_CALC |-> !ovalid_q)
    else $error("twist result would overwrite an undelivered word");

  a_calc_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mtg_pkg::S_CALC |=> ovalid_q)
    else $error("twist cycle did not produce a word");

  a_restart_refills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req_i.restart |=> state_q == mtg_pkg::S_SEED && pending_q)
    else $error("restart request did not start a refill");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= AddrW'(StateWords - 1))
    else $error("read position outside state store");

endmodule

// ===== sv/mtg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mtg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the MT19937 generator, checked against a word predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 8;

  class mt_scoreboard;
    logic [WORD_W-1:0] words [STATE_WORDS];
    int unsigned       pos;
    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] expected_words [$];
    int unsigned       errors;

    function new();
      seed_reg = SEED_RESET;
      errors   = 0;
      refill();
    endfunction

    function void refill();
      logic [WORD_W-1:0] p;
      words[0] = seed_reg;
      for (int unsigned k = 1; k < STATE_WORDS; k++) begin
        p        = words[k-1];
        words[k] = INIT_MULT * (p ^ (p >> 30)) + WORD_W'(k);
      end
      pos = STATE_WORDS;
    endfunction

    function void regenerate();
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] t;
      int unsigned       nxt;
      int unsigned       far_idx;
      for (int unsigned k = 0; k < STATE_WORDS; k++) begin
        nxt     = (k + 1) % STATE_WORDS;
        far_idx = (k + MIDDLE_OFFSET) % STATE_WORDS;
        y       = (words[k] & UPPER_MASK) | (words[nxt] & LOWER_MASK);
        t       = y >> 1;
        if (y[0]) begin
          t = t ^ TWIST_MATRIX;
        end
        words[k] = words[far_idx] ^ t;
      end
      pos = 0;
    endfunction

    function logic [WORD_W-1:0] scramble(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
    endfunction

    function void set_seed(input logic [WORD_W-1:0] v);
      seed_reg = v;
    endfunction

    function void note_request(input logic restart);
      if (restart) begin
        refill();
      end
      if (pos >= STATE_WORDS) begin
        regenerate();
      end
      expected_words.push_back(scramble(words[pos]));
      pos++;
    endfunction

    function void check_word(input logic [WORD_W-1:0] got);
      logic [WORD_W-1:0] want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %08h", $time, got);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          $display("%0t: word mismatch: expected %08h, actual %08h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [WORD_W-1:0] cfg_wdata_i;

  mtg_req_if req ();
  mtg_rsp_if rsp ();

  mersenne_twister_generator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  mt_scoreboard sb;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req.valid      = 1'b0;
    req.restart    = 1'b0;
    rsp.ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycles         = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        sb.check_word(rsp.value);
      end
      if (req.valid && req.ready) begin
        sb.note_request(req.restart);
      end
    end
  end

  task automatic send_request(input logic restart);
    int unsigned gap;
    req.valid   <= 1'b1;
    req.restart <= restart;
    do @(posedge clk_i); while (!req.ready);
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      req.valid   <= 1'b0;
      req.restart <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= $urandom;
    sb.set_seed(v);
  endtask

  task automatic random_phase(input int unsigned n, input int unsigned idle,
                              input int unsigned stall, input bit first_restart);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) == 0) begin
        drain();
      end
      if (i == 0 && first_restart) begin
        send_request(1'b1);
      end else begin
        send_request($urandom_range(0, 511) == 0);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset sequence, seed extremes, restarts back to back
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    write_seed('0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    write_seed('1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    drain();
    send_request(1'b0);
    write_seed($urandom);
    send_request(1'b1);
    send_request(1'b0);
    write_seed(SEED_RESET);
    send_request(1'b1);
    send_request(1'b0);

    write_seed($urandom);
    random_phase(450, 0, 0, 1'b0);
    write_seed(32'h8000_0000);
    random_phase(150, 81, 0, 1'b0);
    write_seed($urandom);
    random_phase(120, 0, 81, 1'b0);
    write_seed($urandom);
    random_phase(80, 18, 18, 1'b1);

    drain();
    repeat (SETTLE_CYCLES * 4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mtg_pkg.sv
sv/mtg_req_if.sv
sv/mtg_rsp_if.sv
sv/mtg_ram.sv
sv/mersenne_twister_generator_unit.sv
verif/tb.sv
